/* design/tiad_pkg.sv */
// tiad_pkg: shared constants, stage types and the arctangent table
// for the interpolated atan2 pipeline
// no dependencies
package tiad_pkg;

    // pipeline shape
    localparam int NUM_STAGES = 10;
    localparam int STG_FRONT  = 0;
    localparam int STG_QUO3   = 1;
    localparam int STG_QUO0   = 4;
    localparam int STG_TABLE  = 5;
    localparam int STG_FRAC2  = 6;
    localparam int STG_FRAC0  = 8;
    localparam int STG_FOLD   = 9;

    localparam logic [3:0] TBL_LAST = 4'd10;

    localparam logic [6:0] DEG_90_7 = 7'd90;
    localparam logic [8:0] DEG_90   = 9'd90;
    localparam logic [8:0] DEG_180  = 9'd180;
    localparam logic [8:0] DEG_270  = 9'd270;
    localparam logic [8:0] DEG_360  = 9'd360;

    // per-word control flags carried down the pipe
    typedef struct packed {
        logic xzero;   // x is zero, angle is fixed
        logic ypos;    // y strictly positive
        logic steep;   // |y| >= |x|, mirror to 90 - v
        logic xneg;
        logic yneg;
    } ctl_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [15:0] den;    // larger magnitude
        logic [19:0] rem;    // running dividend / remainder
        logic [3:0]  quo;    // table index
        logic [5:0]  base;   // table value at index
        logic [2:0]  frac;   // interpolation step
        logic [8:0]  angle;  // final angle
    } stage_t;

    // atan(k/10) in whole degrees
    function automatic logic [5:0] atan_entry(input logic [3:0] idx);
        logic [5:0] val;
        case (idx)
            4'd0:    val = 6'd0;
            4'd1:    val = 6'd6;
            4'd2:    val = 6'd11;
            4'd3:    val = 6'd17;
            4'd4:    val = 6'd22;
            4'd5:    val = 6'd27;
            4'd6:    val = 6'd31;
            4'd7:    val = 6'd35;
            4'd8:    val = 6'd39;
            4'd9:    val = 6'd42;
            default: val = 6'd45;
        endcase
        return val;
    endfunction

endpackage

/* design/table_interpolated_atan2_degrees.sv */
// table_interpolated_atan2_degrees: pipelined integer atan2 in whole degrees
// depends on tiad_pkg (stage types, table, angle constants)
//
// usage
//   sample channel: samp_valid / samp_stall carry one word of x_coord, y_coord
//   (signed 16 bit); a word is taken at a clock edge with samp_valid high and
//   samp_stall low
//   angle channel: ang_valid / ang_stall carry angle_deg, 0..360, unsigned
//   a word taken on the sample channel shows on the angle channel from stage 9
//   throughput: one word per cycle while the pipe does not hold; ten register stages, each holding one word
//     stage 0      magnitudes, octant swap, small magnitude times 10
//     stages 1-4   restoring divide, one quotient bit per stage (index 0..10)
//     stage 5      table read and interpolation product
//     stages 6-8   restoring divide of the product, one bit per stage
//     stage 9      add step, mirror for steep vectors, fold into quadrant
//   stall: while the angle word waits (ang_valid high, ang_stall high) the whole
//   pipe holds and samp_stall is high; nothing is dropped or repeated
//   reset: rst_n low clears every valid bit; the pipe comes up empty
module table_interpolated_atan2_degrees (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               samp_valid,
    output logic               samp_stall,
    input  logic signed [15:0] x_coord,
    input  logic signed [15:0] y_coord,
    output logic               ang_valid,
    input  logic               ang_stall,
    output logic        [8:0]  angle_deg
);

    tiad_pkg::stage_t pipe_reg  [tiad_pkg::NUM_STAGES];
    tiad_pkg::stage_t pipe_next [tiad_pkg::NUM_STAGES];
    logic [tiad_pkg::NUM_STAGES-1:0] valid_reg;
    logic [tiad_pkg::NUM_STAGES-1:0] valid_next;
    logic adv;

    // one restoring divide step: compare against den << sh, returns {bit, rem}
    function automatic logic [20:0] div_step(input logic [19:0] rem,
                                             input logic [15:0] den,
                                             input logic [1:0]  sh);
        logic [19:0] shifted;
        shifted = {4'd0, den} << sh;
        if (rem >= shifted)
        begin
            return {1'b1, rem - shifted};
        end
        return {1'b0, rem};
    endfunction

    // whole pipe moves unless the output word is held by the receiver
    assign adv        = !(valid_reg[tiad_pkg::NUM_STAGES-1] && ang_stall);
    assign samp_stall = !adv;
    assign ang_valid  = valid_reg[tiad_pkg::NUM_STAGES-1];
    assign angle_deg  = pipe_reg[tiad_pkg::NUM_STAGES-1].angle;

    assign valid_next = {valid_reg[tiad_pkg::NUM_STAGES-2:0], samp_valid};

    always_comb
    begin
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] small_mag;
        logic [20:0] step;
        logic [3:0]  i0;
        logic [3:0]  i1;
        logic [5:0]  hi;
        logic [2:0]  dlt;
        logic [6:0]  t;
        logic [6:0]  v;
        logic [8:0]  v9;

        for (int s = 0; s < tiad_pkg::NUM_STAGES; s++)
        begin
            pipe_next[s] = pipe_reg[s];
        end

        // front: magnitudes (-32768 maps to 32768 exactly) and octant swap
        ax = x_coord[15] ? $unsigned(-x_coord) : $unsigned(x_coord);
        ay = y_coord[15] ? $unsigned(-y_coord) : $unsigned(y_coord);
        pipe_next[tiad_pkg::STG_FRONT].ctl.xzero = (x_coord == 16'sd0);
        pipe_next[tiad_pkg::STG_FRONT].ctl.ypos  = !y_coord[15] && (y_coord != 16'sd0);
        pipe_next[tiad_pkg::STG_FRONT].ctl.steep = (ay >= ax);
        pipe_next[tiad_pkg::STG_FRONT].ctl.xneg  = x_coord[15];
        pipe_next[tiad_pkg::STG_FRONT].ctl.yneg  = y_coord[15];
        small_mag = (ay >= ax) ? ax : ay;
        pipe_next[tiad_pkg::STG_FRONT].den = (ay >= ax) ? ay : ax;
        pipe_next[tiad_pkg::STG_FRONT].rem = ({4'd0, small_mag} << 3)
                                           + ({4'd0, small_mag} << 1);
        pipe_next[tiad_pkg::STG_FRONT].quo = 4'd0;

        // quotient bits 3..0
        for (int s = tiad_pkg::STG_QUO3; s <= tiad_pkg::STG_QUO0; s++)
        begin
            pipe_next[s] = pipe_reg[s-1];
            step = div_step(pipe_reg[s-1].rem, pipe_reg[s-1].den,
                            2'(tiad_pkg::STG_QUO0 - s));
            pipe_next[s].rem = step[19:0];
            pipe_next[s].quo[2'(tiad_pkg::STG_QUO0 - s)] = step[20];
        end

        // table read; remainder times table step
        pipe_next[tiad_pkg::STG_TABLE] = pipe_reg[tiad_pkg::STG_TABLE-1];
        i0 = (pipe_reg[tiad_pkg::STG_TABLE-1].quo > tiad_pkg::TBL_LAST)
           ? tiad_pkg::TBL_LAST : pipe_reg[tiad_pkg::STG_TABLE-1].quo;
        i1 = (i0 == tiad_pkg::TBL_LAST) ? tiad_pkg::TBL_LAST : i0 + 4'd1;
        pipe_next[tiad_pkg::STG_TABLE].base = tiad_pkg::atan_entry(i0);
        hi  = tiad_pkg::atan_entry(i1);
        dlt = 3'(hi - tiad_pkg::atan_entry(i0));
        pipe_next[tiad_pkg::STG_TABLE].rem =
            {17'd0, dlt} * {4'd0, pipe_reg[tiad_pkg::STG_TABLE-1].rem[15:0]};
        pipe_next[tiad_pkg::STG_TABLE].frac = 3'd0;

        // interpolation step bits 2..0
        for (int s = tiad_pkg::STG_FRAC2; s <= tiad_pkg::STG_FRAC0; s++)
        begin
            pipe_next[s] = pipe_reg[s-1];
            step = div_step(pipe_reg[s-1].rem, pipe_reg[s-1].den,
                            2'(tiad_pkg::STG_FRAC0 - s));
            pipe_next[s].rem = step[19:0];
            pipe_next[s].frac[2'(tiad_pkg::STG_FRAC0 - s)] = step[20];
        end

        // mirror and quadrant fold
        pipe_next[tiad_pkg::STG_FOLD] = pipe_reg[tiad_pkg::STG_FOLD-1];
        t  = {1'b0, pipe_reg[tiad_pkg::STG_FOLD-1].base}
           + {4'd0, pipe_reg[tiad_pkg::STG_FOLD-1].frac};
        v  = pipe_reg[tiad_pkg::STG_FOLD-1].ctl.steep ? tiad_pkg::DEG_90_7 - t : t;
        v9 = {2'd0, v};
        case ({pipe_reg[tiad_pkg::STG_FOLD-1].ctl.xneg,
               pipe_reg[tiad_pkg::STG_FOLD-1].ctl.yneg})
            2'b00:   pipe_next[tiad_pkg::STG_FOLD].angle = v9;
            2'b10:   pipe_next[tiad_pkg::STG_FOLD].angle = tiad_pkg::DEG_180 - v9;
            2'b01:   pipe_next[tiad_pkg::STG_FOLD].angle = tiad_pkg::DEG_360 - v9;
            default: pipe_next[tiad_pkg::STG_FOLD].angle = tiad_pkg::DEG_180 + v9;
        endcase
        if (pipe_reg[tiad_pkg::STG_FOLD-1].ctl.xzero)
        begin
            pipe_next[tiad_pkg::STG_FOLD].angle =
                pipe_reg[tiad_pkg::STG_FOLD-1].ctl.ypos ? tiad_pkg::DEG_90
                                                         : tiad_pkg::DEG_270;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
        end
    end

    // a nonzero x always leaves a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[tiad_pkg::STG_FRONT] && !pipe_reg[tiad_pkg::STG_FRONT].ctl.xzero
        |-> pipe_reg[tiad_pkg::STG_FRONT].den != 16'd0)
        else $error("zero divisor with nonzero x");

    // index division ends with a proper remainder and index in table range
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[tiad_pkg::STG_QUO0] && !pipe_reg[tiad_pkg::STG_QUO0].ctl.xzero
        |-> (pipe_reg[tiad_pkg::STG_QUO0].rem < {4'd0, pipe_reg[tiad_pkg::STG_QUO0].den})
            && (pipe_reg[tiad_pkg::STG_QUO0].quo <= tiad_pkg::TBL_LAST))
        else $error("index divide out of range");

    // interpolation step stays below the largest table gap
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[tiad_pkg::STG_FRAC0] && !pipe_reg[tiad_pkg::STG_FRAC0].ctl.xzero
        |-> (pipe_reg[tiad_pkg::STG_FRAC0].rem < {4'd0, pipe_reg[tiad_pkg::STG_FRAC0].den})
            && (pipe_reg[tiad_pkg::STG_FRAC0].frac <= 3'd5))
        else $error("interpolation divide out of range");

    // an offered angle word stays within 0..360
    assert property (@(posedge clk) disable iff (!rst_n)
        ang_valid |-> angle_deg <= tiad_pkg::DEG_360)
        else $error("angle above 360");

endmodule
